// ===== design/i2cmc_pkg.sv =====
//------------------------------------------------------------------------------
// i2cmc_pkg
// shared types and codes for the multi-client i2c transaction sequencer
//------------------------------------------------------------------------------
`default_nettype none

package i2cmc_pkg;

    localparam int NUM_CLIENTS_DEF = 8;

    localparam int OP_W    = 3;
    localparam int KIND_W  = 3;
    localparam int PHASE_W = 2;
    localparam int MASK_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 8;
    localparam int ABORT_W = 32;
    localparam int OUT_CLIENT_W = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_ARBITRATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE_BYTE = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_LEN   = 3'd2;
    localparam logic [OP_W-1:0] OP_ISSUE_READ = 3'd3;
    localparam logic [OP_W-1:0] OP_RX_BYTE    = 3'd4;
    localparam logic [OP_W-1:0] OP_ABORT      = 3'd5;
    localparam logic [OP_W-1:0] OP_FLUSHED    = 3'd6;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GRANT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CMD     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BYTE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WFAIL   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RFAIL   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd6;

    // transaction phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WRITE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_READ  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/i2c_multi_client_transaction_sequencer_unit.sv =====
//------------------------------------------------------------------------------
// i2c_multi_client_transaction_sequencer_unit
// multi-client i2c master front end: arbitration, command words, rx and aborts
//------------------------------------------------------------------------------
// Each transaction has a capture step and an execute step: on capture the
// item is registered together with one want flag per position of the
// least-recently-served order, on execute the priority pick, the command word,
// the state update and the load of the result into the output register are
// done. The input side is ready again in the cycle after that, while the
// result still waits in the output register; a new result is only loaded once
// the old one has been taken, so an untaken result holds the execute step back.
// The client order lives in flip-flops, so there is no clearing pass after reset.
`default_nettype none

module i2c_multi_client_transaction_sequencer_unit #(
    parameter int NUM_CLIENTS = i2cmc_pkg::NUM_CLIENTS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input transactions
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [i2cmc_pkg::OP_W-1:0]           s_op,
    input  wire logic [i2cmc_pkg::MASK_W-1:0]         s_write_want_mask,
    input  wire logic [i2cmc_pkg::MASK_W-1:0]         s_read_want_mask,
    input  wire logic                                 s_bus_active,
    input  wire logic [i2cmc_pkg::BYTE_W-1:0]         s_data_byte,
    input  wire logic                                 s_more_bytes,
    input  wire logic                                 s_stop_after,
    input  wire logic [i2cmc_pkg::CNT_W-1:0]          s_read_length,
    input  wire logic [i2cmc_pkg::ABORT_W-1:0]        s_abort_source,
    // result transactions
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [i2cmc_pkg::KIND_W-1:0]              m_result_kind,
    output logic [i2cmc_pkg::OUT_CLIENT_W-1:0]        m_client,
    output logic                                      m_grant_is_read,
    output logic                                      m_cmd_restart,
    output logic                                      m_cmd_stop,
    output logic                                      m_cmd_read,
    output logic [i2cmc_pkg::BYTE_W-1:0]              m_out_byte,
    output logic [i2cmc_pkg::ABORT_W-1:0]             m_abort_code,
    output logic                                      m_transaction_done
);

    // capture and execute strobes from the controller
    i2cmc_pkg::cmd_t cmd;

    // controller: input handshake, two-step sequencing, output valid
    i2cmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // datapath: client order, phase and counters, result register
    i2cmc_dpath #(
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .s_op               (s_op),
        .s_write_want_mask  (s_write_want_mask),
        .s_read_want_mask   (s_read_want_mask),
        .s_bus_active       (s_bus_active),
        .s_data_byte        (s_data_byte),
        .s_more_bytes       (s_more_bytes),
        .s_stop_after       (s_stop_after),
        .s_read_length      (s_read_length),
        .s_abort_source     (s_abort_source),
        .m_result_kind      (m_result_kind),
        .m_client           (m_client),
        .m_grant_is_read    (m_grant_is_read),
        .m_cmd_restart      (m_cmd_restart),
        .m_cmd_stop         (m_cmd_stop),
        .m_cmd_read         (m_cmd_read),
        .m_out_byte         (m_out_byte),
        .m_abort_code       (m_abort_code),
        .m_transaction_done (m_transaction_done)
    );

endmodule

`default_nettype wire

// ===== design/i2cmc_ctrl.sv =====
//------------------------------------------------------------------------------
// i2cmc_ctrl
// sequencing state machine: capture, execute and output register handshake
//------------------------------------------------------------------------------
`default_nettype none

module i2cmc_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    output i2cmc_pkg::cmd_t     cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.execute) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== design/i2cmc_dpath.sv =====
//------------------------------------------------------------------------------
// i2cmc_dpath
// client order, transaction state, arbitration pick and result register
//------------------------------------------------------------------------------
`default_nettype none

module i2cmc_dpath #(
    parameter int NUM_CLIENTS = i2cmc_pkg::NUM_CLIENTS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire i2cmc_pkg::cmd_t                      cmd,
    input  wire logic [i2cmc_pkg::OP_W-1:0]           s_op,
    input  wire logic [i2cmc_pkg::MASK_W-1:0]         s_write_want_mask,
    input  wire logic [i2cmc_pkg::MASK_W-1:0]         s_read_want_mask,
    input  wire logic                                 s_bus_active,
    input  wire logic [i2cmc_pkg::BYTE_W-1:0]         s_data_byte,
    input  wire logic                                 s_more_bytes,
    input  wire logic                                 s_stop_after,
    input  wire logic [i2cmc_pkg::CNT_W-1:0]          s_read_length,
    input  wire logic [i2cmc_pkg::ABORT_W-1:0]        s_abort_source,
    output logic [i2cmc_pkg::KIND_W-1:0]              m_result_kind,
    output logic [i2cmc_pkg::OUT_CLIENT_W-1:0]        m_client,
    output logic                                      m_grant_is_read,
    output logic                                      m_cmd_restart,
    output logic                                      m_cmd_stop,
    output logic                                      m_cmd_read,
    output logic [i2cmc_pkg::BYTE_W-1:0]              m_out_byte,
    output logic [i2cmc_pkg::ABORT_W-1:0]             m_abort_code,
    output logic                                      m_transaction_done
);

    localparam int CLIENT_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

    // client order and transaction state
    logic [CLIENT_W-1:0]                 order_reg [NUM_CLIENTS];
    logic [CLIENT_W-1:0]                 order_next [NUM_CLIENTS];
    logic [i2cmc_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic [CLIENT_W-1:0]                 cur_reg, cur_next;
    logic                                first_reg, first_next;
    logic                                rp_reg, rp_next;
    logic                                wfin_reg, wfin_next;
    logic [i2cmc_pkg::CNT_W-1:0]         to_issue_reg, to_issue_next;
    logic [i2cmc_pkg::CNT_W-1:0]         outst_reg, outst_next;

    // captured transaction
    logic [i2cmc_pkg::OP_W-1:0]          op_reg;
    logic                                busy_reg;
    logic [i2cmc_pkg::BYTE_W-1:0]        data_reg;
    logic                                more_reg;
    logic                                stop_reg;
    logic [i2cmc_pkg::CNT_W-1:0]         rlen_reg;
    logic [i2cmc_pkg::ABORT_W-1:0]       abort_reg;
    logic [NUM_CLIENTS-1:0]              want_any_reg, want_any_next;
    logic [NUM_CLIENTS-1:0]              want_wr_reg, want_wr_next;

    // result fields
    logic [i2cmc_pkg::KIND_W-1:0]        kind;
    logic [CLIENT_W-1:0]                 cl;
    logic                                gread, crs, cst, crd, done, fin;
    logic [i2cmc_pkg::BYTE_W-1:0]        ob;
    logic [i2cmc_pkg::ABORT_W-1:0]       ac;
    logic [CLIENT_W+2:0]                 cl_ext;

    // arbitration pick
    logic                                found;
    logic [CLIENT_W-1:0]                 pick_client;
    logic                                pick_wr;

    // move-to-back
    logic [NUM_CLIENTS-1:0]              after_pos;
    logic                                seen;

    logic [i2cmc_pkg::KIND_W-1:0]        kind_reg;
    logic [i2cmc_pkg::OUT_CLIENT_W-1:0]  client_reg;
    logic                                gread_reg, crs_reg, cst_reg, crd_reg, done_reg;
    logic [i2cmc_pkg::BYTE_W-1:0]        ob_reg;
    logic [i2cmc_pkg::ABORT_W-1:0]       ac_reg;

    // per-position want flags from the masks, looked up through the order
    always_comb begin
        logic [CLIENT_W+3:0] cx;
        for (int i = 0; i < NUM_CLIENTS; i++) begin
            cx = {4'b0, order_reg[i]};
            want_wr_next[i]  = (cx < 8) && s_write_want_mask[cx[2:0]];
            want_any_next[i] = (cx < 8) &&
                (s_write_want_mask[cx[2:0]] || s_read_want_mask[cx[2:0]]);
        end
    end

    // first wanting position in least-recently-served order
    always_comb begin
        found       = 1'b0;
        pick_client = '0;
        pick_wr     = 1'b0;
        for (int i = 0; i < NUM_CLIENTS; i++) begin
            if (!found && want_any_reg[i]) begin
                found       = 1'b1;
                pick_client = order_reg[i];
                pick_wr     = want_wr_reg[i];
            end
        end
    end

    // served client moves to the back, later entries shift forward
    always_comb begin
        seen = 1'b0;
        for (int i = 0; i < NUM_CLIENTS; i++) begin
            seen         = seen || (order_reg[i] == cur_reg);
            after_pos[i] = seen;
        end
        for (int i = 0; i < NUM_CLIENTS - 1; i++) begin
            order_next[i] = after_pos[i] ? order_reg[i+1] : order_reg[i];
        end
        order_next[NUM_CLIENTS-1] = cur_reg;
    end

    always_comb begin
        kind          = i2cmc_pkg::KIND_IGNORED;
        cl            = '0;
        gread         = 1'b0;
        crs           = 1'b0;
        cst           = 1'b0;
        crd           = 1'b0;
        ob            = '0;
        ac            = '0;
        done          = 1'b0;
        fin           = 1'b0;
        phase_next    = phase_reg;
        cur_next      = cur_reg;
        first_next    = first_reg;
        rp_next       = rp_reg;
        wfin_next     = wfin_reg;
        to_issue_next = to_issue_reg;
        outst_next    = outst_reg;

        unique case (op_reg)
            i2cmc_pkg::OP_ARBITRATE: begin
                if (phase_reg == i2cmc_pkg::PH_IDLE) begin
                    kind = i2cmc_pkg::KIND_NONE;
                    if (!busy_reg && found) begin
                        kind          = i2cmc_pkg::KIND_GRANT;
                        cl            = pick_client;
                        gread         = !pick_wr;
                        cur_next      = pick_client;
                        phase_next    = pick_wr ? i2cmc_pkg::PH_WRITE : i2cmc_pkg::PH_READ;
                        first_next    = 1'b1;
                        rp_next       = 1'b0;
                        wfin_next     = 1'b0;
                        to_issue_next = '0;
                        outst_next    = '0;
                    end
                end
            end
            i2cmc_pkg::OP_WRITE_BYTE: begin
                if (phase_reg == i2cmc_pkg::PH_WRITE && !wfin_reg) begin
                    kind       = i2cmc_pkg::KIND_CMD;
                    cl         = cur_reg;
                    crs        = first_reg || rp_reg;
                    cst        = !more_reg || stop_reg;
                    ob         = data_reg;
                    first_next = 1'b0;
                    rp_next    = more_reg && stop_reg;
                    wfin_next  = !more_reg;
                end
            end
            i2cmc_pkg::OP_READ_LEN: begin
                if (phase_reg == i2cmc_pkg::PH_READ && outst_reg == '0) begin
                    kind = i2cmc_pkg::KIND_NONE;
                    cl   = cur_reg;
                    if (rlen_reg == '0) begin
                        fin  = 1'b1;
                        done = 1'b1;
                    end else begin
                        to_issue_next = rlen_reg;
                        outst_next    = rlen_reg;
                    end
                end
            end
            i2cmc_pkg::OP_ISSUE_READ: begin
                if (phase_reg == i2cmc_pkg::PH_READ && to_issue_reg != '0) begin
                    to_issue_next = to_issue_reg - 1'b1;
                    kind          = i2cmc_pkg::KIND_CMD;
                    cl            = cur_reg;
                    crs           = first_reg;
                    cst           = (to_issue_reg == 8'd1);
                    crd           = 1'b1;
                    first_next    = 1'b0;
                end
            end
            i2cmc_pkg::OP_RX_BYTE: begin
                if (phase_reg == i2cmc_pkg::PH_READ && outst_reg > to_issue_reg) begin
                    kind       = i2cmc_pkg::KIND_BYTE;
                    cl         = cur_reg;
                    ob         = data_reg;
                    outst_next = outst_reg - 1'b1;
                    if (outst_reg == 8'd1) begin
                        fin  = 1'b1;
                        done = 1'b1;
                    end
                end
            end
            i2cmc_pkg::OP_ABORT: begin
                if (abort_reg == '0) begin
                    kind = i2cmc_pkg::KIND_NONE;
                end else if (phase_reg != i2cmc_pkg::PH_IDLE) begin
                    kind = (phase_reg == i2cmc_pkg::PH_WRITE) ? i2cmc_pkg::KIND_WFAIL
                                                              : i2cmc_pkg::KIND_RFAIL;
                    cl   = cur_reg;
                    ac   = abort_reg;
                    fin  = 1'b1;
                    done = 1'b1;
                end
            end
            i2cmc_pkg::OP_FLUSHED: begin
                if (phase_reg == i2cmc_pkg::PH_WRITE && wfin_reg) begin
                    kind = i2cmc_pkg::KIND_NONE;
                    cl   = cur_reg;
                    fin  = 1'b1;
                    done = 1'b1;
                end
            end
            default: begin
                kind = i2cmc_pkg::KIND_IGNORED;
            end
        endcase

        if (fin) begin
            phase_next    = i2cmc_pkg::PH_IDLE;
            wfin_next     = 1'b0;
            to_issue_next = '0;
            outst_next    = '0;
        end
    end

    assign cl_ext = {3'b0, cl};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CLIENTS; i++) begin
                order_reg[i] <= CLIENT_W'(i);
            end
            phase_reg    <= i2cmc_pkg::PH_IDLE;
            cur_reg      <= '0;
            first_reg    <= 1'b0;
            rp_reg       <= 1'b0;
            wfin_reg     <= 1'b0;
            to_issue_reg <= '0;
            outst_reg    <= '0;
        end else if (cmd.execute) begin
            if (fin) begin
                order_reg <= order_next;
            end
            phase_reg    <= phase_next;
            cur_reg      <= cur_next;
            first_reg    <= first_next;
            rp_reg       <= rp_next;
            wfin_reg     <= wfin_next;
            to_issue_reg <= to_issue_next;
            outst_reg    <= outst_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg       <= s_op;
            busy_reg     <= s_bus_active;
            data_reg     <= s_data_byte;
            more_reg     <= s_more_bytes;
            stop_reg     <= s_stop_after;
            rlen_reg     <= s_read_length;
            abort_reg    <= s_abort_source;
            want_any_reg <= want_any_next;
            want_wr_reg  <= want_wr_next;
        end
        if (cmd.execute) begin
            kind_reg   <= kind;
            client_reg <= cl_ext[2:0];
            gread_reg  <= gread;
            crs_reg    <= crs;
            cst_reg    <= cst;
            crd_reg    <= crd;
            ob_reg     <= ob;
            ac_reg     <= ac;
            done_reg   <= done;
        end
    end

    assign m_result_kind      = kind_reg;
    assign m_client           = client_reg;
    assign m_grant_is_read    = gread_reg;
    assign m_cmd_restart      = crs_reg;
    assign m_cmd_stop         = cst_reg;
    assign m_cmd_read         = crd_reg;
    assign m_out_byte         = ob_reg;
    assign m_abort_code       = ac_reg;
    assign m_transaction_done = done_reg;

endmodule

`default_nettype wire

// ===== design/i2cmc_chk.sv =====
//------------------------------------------------------------------------------
// i2cmc_chk
// port-level checks for the transaction sequencer, bound to the top level
//------------------------------------------------------------------------------
`default_nettype none

module i2cmc_chk (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_valid,
    input wire logic                                 s_ready,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic [i2cmc_pkg::KIND_W-1:0]         m_result_kind,
    input wire logic                                 m_grant_is_read,
    input wire logic                                 m_cmd_restart,
    input wire logic                                 m_cmd_stop,
    input wire logic                                 m_cmd_read,
    input wire logic                                 m_transaction_done
);

    // a result that is not taken stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

    // one transaction in work at a time: ready drops right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one is in work");

    // command bits appear only in command results
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_cmd_restart || m_cmd_stop || m_cmd_read)
            |-> m_result_kind == i2cmc_pkg::KIND_CMD)
        else $error("command bits outside a command result");

    // a grant never ends a transaction, and read grants only come with grants
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_grant_is_read |-> m_result_kind == i2cmc_pkg::KIND_GRANT
            && !m_transaction_done)
        else $error("read grant flag on a non-grant or done result");

endmodule

bind i2c_multi_client_transaction_sequencer_unit i2cmc_chk u_i2cmc_chk (.*);

`default_nettype wire
